// ----- sv/plce_pkg.sv -----
// ----------------------------------------------------------------------------
// Curve engine package
// Shared widths, register codes and lane result types.
// ----------------------------------------------------------------------------
package plce_pkg;

  localparam int MAX_NODES = 64;
  localparam int LANES     = 4;
  localparam int LANE_W    = $clog2(LANES);
  localparam int ROWS      = (MAX_NODES + LANES - 1) / LANES;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);

  localparam int POS_W     = 24;
  localparam int VAL_W     = 16;
  localparam int SAMPLE_W  = 17;
  localparam int NCH       = 3;
  localparam int BYTE_W    = 8;
  localparam int WIDE_W    = 28;
  localparam int SPAN_W    = POS_W + 1;
  localparam int PROD_W    = SAMPLE_W + 1 + SPAN_W;
  localparam int FRAC_W    = 16;
  localparam int T_W       = 16;
  localparam int DIV_CNT_W = $clog2(T_W + 1);
  localparam int VS_W      = 2 * VAL_W + 2;
  localparam int ACC_W     = VS_W + 9;
  localparam int ROUND_SH  = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [POS_W-1:0] RANGE_MIN_RST = 24'hFC0000;
  localparam logic [POS_W-1:0] RANGE_MAX_RST = 24'h0BFF00;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_MIN = 2'd0,
    REG_RANGE_MAX = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
  } lane_res_t;

  typedef struct packed {
    logic              found;
    logic [LANE_W-1:0] lane;
    logic [POS_W-1:0]  p1;
    logic [POS_W-1:0]  p2;
  } merge_res_t;

endpackage

// ----- sv/plce_if.sv -----
// ----------------------------------------------------------------------------
// Curve engine channels
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface plce_req_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [plce_pkg::POS_W-1:0]   node_position;
  logic [plce_pkg::VAL_W-1:0]          value_red;
  logic [plce_pkg::VAL_W-1:0]          value_green;
  logic [plce_pkg::VAL_W-1:0]          value_blue;
  logic [plce_pkg::SAMPLE_W-1:0]       sample_position;

  modport source (output valid, command, node_position, value_red, value_green, value_blue,
                  sample_position, input ready);
  modport sink (input valid, command, node_position, value_red, value_green, value_blue,
                sample_position, output ready);
endinterface

interface plce_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [plce_pkg::BYTE_W-1:0] out_red;
  logic [plce_pkg::BYTE_W-1:0] out_green;
  logic [plce_pkg::BYTE_W-1:0] out_blue;
  logic                        node_rejected;

  modport source (output valid, out_red, out_green, out_blue, node_rejected, input ready);
  modport sink (input valid, out_red, out_green, out_blue, node_rejected, output ready);
endinterface

interface plce_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [plce_pkg::CFG_IDX_W-1:0] index;
  logic [plce_pkg::POS_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/plce_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/plce_lane.sv -----
// ----------------------------------------------------------------------------
// Curve engine scan lane
// Holds one bank of node positions and tests the segment that ends at the
// entry read from it.
// ----------------------------------------------------------------------------
module plce_lane (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [plce_pkg::ROW_W-1:0]         waddr_i,
  input  logic [plce_pkg::POS_W-1:0]         wdata_i,
  input  logic [plce_pkg::ROW_W-1:0]         raddr_i,
  input  logic [plce_pkg::POS_W-1:0]         prev_i,
  input  logic signed [plce_pkg::WIDE_W-1:0] pos_i,
  input  logic [plce_pkg::CNT_W-1:0]         idx_i,
  input  logic [plce_pkg::CNT_W-1:0]         cnt_i,
  output plce_pkg::lane_res_t                res_o
);

  logic [plce_pkg::POS_W-1:0]         rd_pos;
  logic signed [plce_pkg::WIDE_W-1:0] lo_ext;
  logic signed [plce_pkg::WIDE_W-1:0] hi_ext;
  logic                               in_table;

  plce_ram #(
    .WIDTH(plce_pkg::POS_W),
    .DEPTH(plce_pkg::ROWS)
  ) u_bank (
    .clk_i  (clk_i),
    .we_i   (we_i),
    .waddr_i(waddr_i),
    .wdata_i(wdata_i),
    .raddr_i(raddr_i),
    .rdata_o(rd_pos)
  );

  assign lo_ext = $signed({{(plce_pkg::WIDE_W - plce_pkg::POS_W){prev_i[plce_pkg::POS_W-1]}},
                           prev_i});
  assign hi_ext = $signed({{(plce_pkg::WIDE_W - plce_pkg::POS_W){rd_pos[plce_pkg::POS_W-1]}},
                           rd_pos});
  assign in_table = (idx_i != '0) && (idx_i < cnt_i);

  assign res_o.hit = in_table && (lo_ext <= pos_i) && (pos_i < hi_ext);
  assign res_o.pos = rd_pos;

endmodule

// ----- sv/plce_merge.sv -----
// ----------------------------------------------------------------------------
// Curve engine lane merge
// Picks the lowest lane that found its segment and forwards its end points.
// ----------------------------------------------------------------------------
module plce_merge (
  input  plce_pkg::lane_res_t [plce_pkg::LANES-1:0]                        lanes_i,
  input  logic [plce_pkg::LANES-1:0][plce_pkg::POS_W-1:0]                  prev_i,
  output plce_pkg::merge_res_t                                             res_o
);

  always_comb begin
    res_o = '0;
    for (int k = plce_pkg::LANES - 1; k >= 0; k--) begin
      if (lanes_i[k].hit) begin
        res_o.found = 1'b1;
        res_o.lane  = plce_pkg::LANE_W'(k);
        res_o.p1    = prev_i[k];
        res_o.p2    = lanes_i[k].pos;
      end
    end
  end

endmodule

// ----- sv/plce_div.sv -----
// ----------------------------------------------------------------------------
// Curve engine fraction divider
// Restoring divider, one quotient bit per cycle, for num * 2^16 / den with
// num below den.
// ----------------------------------------------------------------------------
module plce_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [plce_pkg::POS_W-1:0]     num_i,
  input  logic [plce_pkg::POS_W-1:0]     den_i,
  output logic                           done_o,
  output logic [plce_pkg::T_W-1:0]       quot_o
);

  logic [plce_pkg::POS_W-1:0]     rem_q;
  logic [plce_pkg::POS_W-1:0]     den_q;
  logic [plce_pkg::T_W-1:0]       quot_q;
  logic [plce_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic [plce_pkg::POS_W:0]       rem_sh;
  logic [plce_pkg::POS_W:0]       rem_sub;
  logic                           ge;
  logic [plce_pkg::POS_W-1:0]     rem_d;

  always_comb begin
    rem_sh  = {rem_q, 1'b0};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = (rem_sh >= {1'b0, den_q});
    rem_d   = ge ? rem_sub[plce_pkg::POS_W-1:0] : rem_sh[plce_pkg::POS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      den_q  <= '0;
      quot_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= num_i;
        den_q  <= den_i;
        quot_q <= '0;
        cnt_q  <= plce_pkg::DIV_CNT_W'(plce_pkg::T_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q  <= rem_d;
        quot_q <= {quot_q[plce_pkg::T_W-2:0], ge};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == plce_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- sv/piecewise_linear_curve_eval_unit.sv -----
// ----------------------------------------------------------------------------
// Piecewise-linear curve evaluator
// Add requests need no search and an empty table yields zero; samples beyond the
// range ends take the first or last node's value, and in range four scan lanes
// search the segments row by row while a serial divider forms the fraction. One
// request at a time; the next is taken once the result is in the output register.
// Reset initialises node count, range registers and control state, not node storage.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_eval_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  plce_cfg_if.sink     cfg_i,
  plce_req_if.sink     req_i,
  plce_rsp_if.source   rsp_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_POS, ST_CMP, ST_SCAN, ST_DIV,
    ST_FETCH, ST_LOAD, ST_MULV, ST_SUM, ST_BYTE, ST_FIN
  } state_e;

  localparam int LANES      = plce_pkg::LANES;
  localparam int POS_W      = plce_pkg::POS_W;
  localparam int VAL_W      = plce_pkg::VAL_W;
  localparam int NCH        = plce_pkg::NCH;
  localparam int WIDE_W     = plce_pkg::WIDE_W;
  localparam int SPAN_W     = plce_pkg::SPAN_W;
  localparam int VS_W       = plce_pkg::VS_W;
  localparam int ACC_W      = plce_pkg::ACC_W;
  localparam int ROUND_BITS = plce_pkg::ROUND_SH;

  state_e                                state_q;
  logic [plce_pkg::CNT_W-1:0]            cnt_q;
  logic [POS_W-1:0]                      rmin_q;
  logic [POS_W-1:0]                      rmax_q;
  logic [plce_pkg::SAMPLE_W-1:0]         x_q;
  logic signed [plce_pkg::PROD_W-1:0]    prod_q;
  logic signed [WIDE_W-1:0]              pos_q;
  logic [plce_pkg::ROW_W-1:0]            row_q;
  logic [plce_pkg::ROW_W-1:0]            cmp_row_q;
  logic [plce_pkg::ROW_W-1:0]            last_row_q;
  logic                                  cmp_vld_q;
  logic [POS_W-1:0]                      prev_last_q;
  logic [plce_pkg::IDX_W-1:0]            seg_q;
  logic [plce_pkg::IDX_W-1:0]            fetch_addr_q;
  logic [1:0]                            vstep_q;
  logic [plce_pkg::T_W-1:0]              t_q;
  logic [VAL_W-1:0]                      a_q [NCH];
  logic [VAL_W-1:0]                      b_q [NCH];
  logic signed [VS_W-1:0]                mprod_q [NCH];
  logic signed [VS_W-1:0]                vs_q [NCH];
  logic [plce_pkg::BYTE_W-1:0]           res_q [NCH];
  logic                                  res_rej_q;
  logic [plce_pkg::BYTE_W-1:0]           out_q [NCH];
  logic                                  out_rej_q;
  logic                                  out_vld_q;

  logic                                  req_acc;
  logic                                  add_ok;
  logic [plce_pkg::ROW_W-1:0]            wrow;
  logic [LANES-1:0]                      lane_we;
  logic [LANES-1:0][plce_pkg::CNT_W-1:0] lane_idx;
  logic [LANES-1:0][POS_W-1:0]           prev_pos;
  plce_pkg::lane_res_t [LANES-1:0]       lane_res;
  plce_pkg::merge_res_t                  mres;
  logic signed [WIDE_W-1:0]              rmin_ext;
  logic signed [WIDE_W-1:0]              rmax_ext;
  logic signed [SPAN_W-1:0]              span;
  logic signed [WIDE_W-1:0]              num_w;
  logic signed [SPAN_W-1:0]              den_w;
  logic                                  div_start;
  logic                                  div_done;
  logic [plce_pkg::T_W-1:0]              div_quot;
  logic [plce_pkg::IDX_W-1:0]            vraddr;
  logic [NCH*VAL_W-1:0]                  vrdata;
  logic [plce_pkg::CNT_W-1:0]            hit_idx;

  function automatic logic [plce_pkg::BYTE_W-1:0] to_byte(input logic signed [VS_W-1:0] vs);
    logic [ACC_W-1:0]          v;
    logic [ACC_W-1:0]          m;
    logic [ACC_W-ROUND_BITS-1:0] b;
    v = ACC_W'($unsigned(vs));
    m = (v << 8) - v + (ACC_W'(1) << (plce_pkg::ROUND_SH - 1));
    b = m[ACC_W-1:plce_pkg::ROUND_SH];
    if (vs < 0) begin
      return '0;
    end else if (b > (ACC_W-ROUND_BITS)'(255)) begin
      return '1;
    end else begin
      return b[plce_pkg::BYTE_W-1:0];
    end
  endfunction

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign add_ok      = req_acc && (req_i.command == plce_pkg::CMD_ADD) &&
                       (cnt_q < plce_pkg::CNT_W'(plce_pkg::MAX_NODES));
  assign wrow        = plce_pkg::ROW_W'(cnt_q >> plce_pkg::LANE_W);

  assign rmin_ext = $signed({{(WIDE_W - POS_W){rmin_q[POS_W-1]}}, rmin_q});
  assign rmax_ext = $signed({{(WIDE_W - POS_W){rmax_q[POS_W-1]}}, rmax_q});
  assign span     = $signed({rmax_q[POS_W-1], rmax_q}) - $signed({rmin_q[POS_W-1], rmin_q});

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    assign lane_we[k]  = add_ok && (cnt_q[plce_pkg::LANE_W-1:0] == plce_pkg::LANE_W'(k));
    assign lane_idx[k] = (plce_pkg::CNT_W'(cmp_row_q) << plce_pkg::LANE_W) |
                         plce_pkg::CNT_W'(k);
    if (k == 0) begin : g_first
      assign prev_pos[k] = prev_last_q;
    end else begin : g_next
      assign prev_pos[k] = lane_res[k-1].pos;
    end

    plce_lane u_lane (
      .clk_i  (clk_i),
      .we_i   (lane_we[k]),
      .waddr_i(wrow),
      .wdata_i(req_i.node_position),
      .raddr_i(row_q),
      .prev_i (prev_pos[k]),
      .pos_i  (pos_q),
      .idx_i  (lane_idx[k]),
      .cnt_i  (cnt_q),
      .res_o  (lane_res[k])
    );
  end

  plce_merge u_merge (
    .lanes_i(lane_res),
    .prev_i (prev_pos),
    .res_o  (mres)
  );

  assign hit_idx   = (plce_pkg::CNT_W'(cmp_row_q) << plce_pkg::LANE_W) |
                     plce_pkg::CNT_W'(mres.lane);
  assign num_w     = pos_q - $signed({{(WIDE_W - POS_W){mres.p1[POS_W-1]}}, mres.p1});
  assign den_w     = $signed({mres.p2[POS_W-1], mres.p2}) - $signed({mres.p1[POS_W-1], mres.p1});
  assign div_start = (state_q == ST_SCAN) && cmp_vld_q && mres.found;

  plce_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_w[POS_W-1:0]),
    .den_i  (den_w[POS_W-1:0]),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    vraddr = fetch_addr_q;
    if (state_q == ST_DIV) begin
      vraddr = (vstep_q == 2'd0) ? (seg_q - 1'b1) : seg_q;
    end
  end

  plce_ram #(
    .WIDTH(NCH * VAL_W),
    .DEPTH(plce_pkg::MAX_NODES)
  ) u_values (
    .clk_i  (clk_i),
    .we_i   (add_ok),
    .waddr_i(cnt_q[plce_pkg::IDX_W-1:0]),
    .wdata_i({req_i.value_blue, req_i.value_green, req_i.value_red}),
    .raddr_i(vraddr),
    .rdata_o(vrdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      rmin_q       <= plce_pkg::RANGE_MIN_RST;
      rmax_q       <= plce_pkg::RANGE_MAX_RST;
      x_q          <= '0;
      prod_q       <= '0;
      pos_q        <= '0;
      row_q        <= '0;
      cmp_row_q    <= '0;
      last_row_q   <= '0;
      cmp_vld_q    <= 1'b0;
      prev_last_q  <= '0;
      seg_q        <= '0;
      fetch_addr_q <= '0;
      vstep_q      <= '0;
      t_q          <= '0;
      res_rej_q    <= 1'b0;
      out_rej_q    <= 1'b0;
      out_vld_q    <= 1'b0;
      for (int c = 0; c < NCH; c++) begin
        a_q[c]     <= '0;
        b_q[c]     <= '0;
        mprod_q[c] <= '0;
        vs_q[c]    <= '0;
        res_q[c]   <= '0;
        out_q[c]   <= '0;
      end
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.index == plce_pkg::REG_RANGE_MIN) begin
          rmin_q <= cfg_i.data;
        end else if (cfg_i.index == plce_pkg::REG_RANGE_MAX) begin
          rmax_q <= cfg_i.data;
        end
      end

      if (rsp_o.ready && (state_q != ST_FIN)) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            unique case (req_i.command)
              plce_pkg::CMD_ADD: begin
                for (int c = 0; c < NCH; c++) begin
                  res_q[c] <= '0;
                end
                res_rej_q <= !add_ok;
                if (add_ok) begin
                  cnt_q <= cnt_q + 1'b1;
                end
                state_q <= ST_FIN;
              end
              plce_pkg::CMD_EVAL: begin
                x_q     <= req_i.sample_position;
                state_q <= ST_MUL;
              end
            endcase
          end
        end
        ST_MUL: begin
          prod_q  <= $signed({1'b0, x_q}) * span;
          state_q <= ST_POS;
        end
        ST_POS: begin
          pos_q   <= rmin_ext + $signed({prod_q[plce_pkg::PROD_W-1],
                                         prod_q[plce_pkg::PROD_W-1:plce_pkg::FRAC_W]});
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          res_rej_q <= 1'b0;
          if (cnt_q == '0) begin
            for (int c = 0; c < NCH; c++) begin
              res_q[c] <= '0;
            end
            state_q <= ST_FIN;
          end else if (pos_q < rmin_ext) begin
            fetch_addr_q <= '0;
            state_q      <= ST_FETCH;
          end else if (pos_q > rmax_ext) begin
            fetch_addr_q <= plce_pkg::IDX_W'(cnt_q - 1'b1);
            state_q      <= ST_FETCH;
          end else begin
            row_q      <= '0;
            cmp_vld_q  <= 1'b0;
            last_row_q <= plce_pkg::ROW_W'((cnt_q - 1'b1) >> plce_pkg::LANE_W);
            state_q    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          row_q     <= row_q + 1'b1;
          cmp_row_q <= row_q;
          cmp_vld_q <= 1'b1;
          if (cmp_vld_q) begin
            if (mres.found) begin
              seg_q   <= plce_pkg::IDX_W'(hit_idx);
              vstep_q <= '0;
              state_q <= ST_DIV;
            end else if (cmp_row_q == last_row_q) begin
              for (int c = 0; c < NCH; c++) begin
                res_q[c] <= '0;
              end
              state_q <= ST_FIN;
            end else begin
              prev_last_q <= lane_res[LANES-1].pos;
            end
          end
        end
        ST_DIV: begin
          if (vstep_q != 2'd3) begin
            vstep_q <= vstep_q + 1'b1;
          end
          for (int c = 0; c < NCH; c++) begin
            if (vstep_q == 2'd1) begin
              a_q[c] <= vrdata[c*VAL_W +: VAL_W];
            end
            if (vstep_q == 2'd2) begin
              b_q[c] <= vrdata[c*VAL_W +: VAL_W];
            end
          end
          if (div_done) begin
            t_q     <= div_quot;
            state_q <= ST_MULV;
          end
        end
        ST_FETCH: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          for (int c = 0; c < NCH; c++) begin
            a_q[c] <= vrdata[c*VAL_W +: VAL_W];
            b_q[c] <= vrdata[c*VAL_W +: VAL_W];
          end
          t_q     <= '0;
          state_q <= ST_MULV;
        end
        ST_MULV: begin
          for (int c = 0; c < NCH; c++) begin
            mprod_q[c] <= $signed({1'b0, t_q}) *
                          ($signed({1'b0, b_q[c]}) - $signed({1'b0, a_q[c]}));
          end
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          for (int c = 0; c < NCH; c++) begin
            vs_q[c] <= $signed({2'b00, a_q[c], {plce_pkg::FRAC_W{1'b0}}}) + mprod_q[c];
          end
          state_q <= ST_BYTE;
        end
        ST_BYTE: begin
          for (int c = 0; c < NCH; c++) begin
            res_q[c] <= to_byte(vs_q[c]);
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_vld_q || rsp_o.ready) begin
            for (int c = 0; c < NCH; c++) begin
              out_q[c] <= res_q[c];
            end
            out_rej_q <= res_rej_q;
            out_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.out_red       = out_q[0];
  assign rsp_o.out_green     = out_q[1];
  assign rsp_o.out_blue      = out_q[2];
  assign rsp_o.node_rejected = out_rej_q;

endmodule

// ----- sv/plce_checker.sv -----
// ----------------------------------------------------------------------------
// Curve engine port checker
// Watches the request and response channels of the curve evaluator.
// ----------------------------------------------------------------------------
module plce_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [plce_pkg::BYTE_W-1:0] out_red_i,
  input logic [plce_pkg::BYTE_W-1:0] out_green_i,
  input logic [plce_pkg::BYTE_W-1:0] out_blue_i,
  input logic                        node_rejected_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(out_red_i) && $stable(out_green_i) &&
                                    $stable(out_blue_i) && $stable(node_rejected_i))
    else $error("response changed while stalled");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && node_rejected_i |-> out_red_i == '0 && out_green_i == '0 &&
                                       out_blue_i == '0)
    else $error("rejected add carries channel data");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in flight");

endmodule

bind piecewise_linear_curve_eval_unit plce_checker u_plce_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .out_red_i      (rsp_o.out_red),
  .out_green_i    (rsp_o.out_green),
  .out_blue_i     (rsp_o.out_blue),
  .node_rejected_i(rsp_o.node_rejected)
);

// ----- tb/tb_piecewise_linear_curve_eval_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Curve evaluator testbench
// Drives node-add and evaluate requests plus range register writes into the
// curve evaluator. A behavioral model in this file tracks the node table and
// the range and predicts every response. A short directed table comes first,
// followed by random phases over several range settings. Both sides insert
// random idle cycles, and one long response stall fills the block.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_curve_eval_unit;

  localparam int     POS_W        = plce_pkg::POS_W;
  localparam int     VAL_W        = plce_pkg::VAL_W;
  localparam int     SAMPLE_W     = plce_pkg::SAMPLE_W;
  localparam int     BYTE_W       = plce_pkg::BYTE_W;
  localparam int     NCH          = plce_pkg::NCH;
  localparam int     CFG_IDX_W    = plce_pkg::CFG_IDX_W;
  localparam int     MAX_NODES    = plce_pkg::MAX_NODES;
  localparam int     RUN_LIMIT    = 400000;
  localparam int     PHASES       = 10;
  localparam int     PHASE_ITEMS  = 123;
  localparam int     STALL_CYCLES = 600;
  localparam int     DRAIN_CYCLES = 100;
  localparam int     IDLE_PCT     = 9;
  localparam longint FRAC_ONE     = 64'sd65536;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 2'd3;

  typedef struct packed {
    logic                      cmd;
    logic [POS_W-1:0]          node_pos;
    logic [NCH-1:0][VAL_W-1:0] val;
    logic [SAMPLE_W-1:0]       sample;
  } curve_req_t;

  typedef struct packed {
    logic [NCH-1:0][BYTE_W-1:0] rgb;
    logic                       rejected;
  } curve_rsp_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [POS_W-1:0]       reg_data;
    curve_req_t             req;
    bit                     zero_known;
  } directed_row_t;

  logic clk;
  logic rst_n;

  plce_req_if req_if ();
  plce_rsp_if rsp_if ();
  plce_cfg_if cfg_if ();

  piecewise_linear_curve_eval_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic signed [POS_W-1:0]   range_lo = plce_pkg::RANGE_MIN_RST;
  logic signed [POS_W-1:0]   range_hi = plce_pkg::RANGE_MAX_RST;
  int                        node_cnt = 0;
  logic signed [POS_W-1:0]   node_pos_tab [MAX_NODES];
  logic [NCH-1:0][VAL_W-1:0] node_val_tab [MAX_NODES];

  curve_rsp_t    expected_q [$];
  directed_row_t rows [$];
  string         chan_name [NCH] = '{"red", "green", "blue"};
  int            errors   = 0;
  int            cycles   = 0;
  int            accepted = 0;
  bit            calm     = 1'b0;
  bit            rsp_hold = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // Updates the node table for add requests and returns the response the
  // block should give for this request.
  function automatic curve_rsp_t predict_curve(curve_req_t r);
    curve_rsp_t                res;
    longint                    lo, hi, pos, p1, p2, t, a, b, vs, byte_v;
    logic [NCH-1:0][VAL_W-1:0] base_v, next_v;
    bit                        found;
    res = '0;
    found = 1'b0;
    t = 0;
    if (r.cmd == plce_pkg::CMD_ADD) begin
      if (node_cnt >= MAX_NODES) begin
        res.rejected = 1'b1;
      end else begin
        node_pos_tab[node_cnt] = r.node_pos;
        node_val_tab[node_cnt] = r.val;
        node_cnt++;
      end
      return res;
    end
    if (node_cnt == 0) return res;
    lo = longint'(range_lo);
    hi = longint'(range_hi);
    pos = lo + ((longint'(r.sample) * (hi - lo)) >>> 16);
    if (pos < lo) begin
      base_v = node_val_tab[0];
      next_v = base_v;
      found = 1'b1;
    end else if (pos > hi) begin
      base_v = node_val_tab[node_cnt-1];
      next_v = base_v;
      found = 1'b1;
    end else begin
      for (int i = 1; i < node_cnt; i++) begin
        if (!found) begin
          p1 = longint'(node_pos_tab[i-1]);
          p2 = longint'(node_pos_tab[i]);
          if (pos >= p1 && pos < p2) begin
            t = ((pos - p1) * FRAC_ONE) / (p2 - p1);
            base_v = node_val_tab[i-1];
            next_v = node_val_tab[i];
            found = 1'b1;
          end
        end
      end
    end
    if (found) begin
      for (int c = 0; c < NCH; c++) begin
        a = longint'(base_v[c]);
        b = longint'(next_v[c]);
        vs = a * FRAC_ONE + t * (b - a);
        if (vs < 0) vs = 0;
        byte_v = (255 * vs + (longint'(1) << 30)) >>> 31;
        if (byte_v > 255) byte_v = 255;
        res.rgb[c] = byte_v[BYTE_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic void row_req(logic cmd, int pos, int red, int green, int blue,
                                  int sample, bit zero_known);
    directed_row_t row;
    row.kind          = ROW_REQ;
    row.reg_idx       = plce_pkg::REG_RANGE_MIN;
    row.reg_data      = '0;
    row.req.cmd       = cmd;
    row.req.node_pos  = pos[POS_W-1:0];
    row.req.val[0]    = red[VAL_W-1:0];
    row.req.val[1]    = green[VAL_W-1:0];
    row.req.val[2]    = blue[VAL_W-1:0];
    row.req.sample    = sample[SAMPLE_W-1:0];
    row.zero_known    = zero_known;
    rows.push_back(row);
  endfunction

  function automatic void row_cfg(logic [CFG_IDX_W-1:0] idx, int data);
    directed_row_t row;
    row.kind       = ROW_CFG;
    row.reg_idx    = idx;
    row.reg_data   = data[POS_W-1:0];
    row.req        = '0;
    row.zero_known = 1'b0;
    rows.push_back(row);
  endfunction

  // Offers one request, starting and ending at a falling edge. When the
  // response is known to be all zero, that value is expected directly.
  task automatic send_request(input curve_req_t r, input bit zero_known);
    curve_rsp_t predicted;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.command         = r.cmd;
    req_if.node_position   = r.node_pos;
    req_if.value_red       = r.val[0];
    req_if.value_green     = r.val[1];
    req_if.value_blue      = r.val[2];
    req_if.sample_position = r.sample;
    req_if.valid           = 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predicted = predict_curve(r);
    expected_q.push_back(zero_known ? curve_rsp_t'('0) : predicted);
    accepted++;
    @(negedge clk);
  endtask

  // Waits until every response is back, then writes one configuration register.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] data);
    req_if.valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_if.index = idx;
    cfg_if.data  = data;
    cfg_if.valid = 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == plce_pkg::REG_RANGE_MIN) range_lo = data;
    else if (idx == plce_pkg::REG_RANGE_MAX) range_hi = data;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  initial begin : rsp_driver
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready = !rsp_hold && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin : backpressure
    wait (accepted >= 300);
    rsp_hold = 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    rsp_hold = 1'b0;
  end

  always @(posedge clk) begin : check_results
    curve_rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want = expected_q.pop_front();
        if (rsp_if.out_red !== want.rgb[0])
          report_mismatch($sformatf("%s got %0d want %0d", chan_name[0],
                                    rsp_if.out_red, want.rgb[0]));
        if (rsp_if.out_green !== want.rgb[1])
          report_mismatch($sformatf("%s got %0d want %0d", chan_name[1],
                                    rsp_if.out_green, want.rgb[1]));
        if (rsp_if.out_blue !== want.rgb[2])
          report_mismatch($sformatf("%s got %0d want %0d", chan_name[2],
                                    rsp_if.out_blue, want.rgb[2]));
        if (rsp_if.node_rejected !== want.rejected)
          report_mismatch($sformatf("node_rejected got %0d want %0d",
                                    rsp_if.node_rejected, want.rejected));
      end
    end
  end

  initial begin : stimulus
    curve_req_t              r;
    logic signed [POS_W-1:0] lo_v, hi_v, swap_v;
    longint                  next_pos;
    rst_n                  = 1'b0;
    req_if.valid           = 1'b0;
    req_if.command         = plce_pkg::CMD_ADD;
    req_if.node_position   = '0;
    req_if.value_red       = '0;
    req_if.value_green     = '0;
    req_if.value_blue      = '0;
    req_if.sample_position = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = plce_pkg::REG_RANGE_MIN;
    cfg_if.data            = '0;

    // Empty table, a single node, then a two-node segment over the reset range.
    row_req(plce_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 1'b1);
    row_req(plce_pkg::CMD_EVAL, 0, 0, 0, 0, 131071, 1'b1);
    row_req(plce_pkg::CMD_ADD, -262144, 0, 32768, 65535, 0, 1'b1);
    row_req(plce_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 1'b1);
    row_req(plce_pkg::CMD_ADD, 786176, 65535, 0, 32768, 0, 1'b1);
    row_req(plce_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 1'b0);
    row_req(plce_pkg::CMD_EVAL, 0, 0, 0, 0, 65536, 1'b0);
    row_req(plce_pkg::CMD_EVAL, 0, 0, 0, 0, 65535, 1'b0);
    row_req(plce_pkg::CMD_EVAL, 0, 0, 0, 0, 32768, 1'b0);
    row_req(plce_pkg::CMD_EVAL, 0, 0, 0, 0, 131071, 1'b0);
    // Nodes out of order and at the extreme positions.
    row_req(plce_pkg::CMD_ADD, -8388608, 65535, 65535, 65535, 0, 1'b1);
    row_req(plce_pkg::CMD_EVAL, 0, 0, 0, 0, 131071, 1'b0);
    row_req(plce_pkg::CMD_ADD, 8388607, 0, 0, 0, 65536, 1'b1);
    // Inverted range, then a write to an unmapped register.
    row_cfg(plce_pkg::REG_RANGE_MIN, 786176);
    row_cfg(plce_pkg::REG_RANGE_MAX, -262144);
    row_req(plce_pkg::CMD_EVAL, 0, 0, 0, 0, 32768, 1'b0);
    row_req(plce_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 1'b0);
    row_req(plce_pkg::CMD_EVAL, 0, 0, 0, 0, 65536, 1'b0);
    row_cfg(REG_UNMAPPED_A, 0);
    row_req(plce_pkg::CMD_EVAL, 0, 0, 0, 0, 98304, 1'b0);
    row_cfg(plce_pkg::REG_RANGE_MIN, -262144);
    row_cfg(plce_pkg::REG_RANGE_MAX, 786176);
    row_req(plce_pkg::CMD_EVAL, 0, 0, 0, 0, 16384, 1'b0);

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[k]) begin
      if (rows[k].kind == ROW_CFG) write_reg(rows[k].reg_idx, rows[k].reg_data);
      else send_request(rows[k].req, rows[k].zero_known);
    end

    // New nodes mostly ascend from the bottom of the position space, so the
    // table fills with real segments and then rejects further adds.
    next_pos = -64'sd8388608;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin lo_v = 24'sh800000; hi_v = 24'sh7FFFFF; end
        1: begin lo_v = plce_pkg::RANGE_MIN_RST; hi_v = plce_pkg::RANGE_MAX_RST; end
        2: begin lo_v = 24'sh7FFFFF; hi_v = 24'sh800000; end
        3: begin lo_v = '0; hi_v = '0; end
        4: begin lo_v = 24'sh7FFFFF; hi_v = 24'sh7FFFFF; end
        default: begin
          lo_v = POS_W'($urandom_range(0, 24'hFFFFFF));
          hi_v = POS_W'($urandom_range(0, 24'hFFFFFF));
          if (ph != 7 && lo_v > hi_v) begin
            swap_v = lo_v;
            lo_v = hi_v;
            hi_v = swap_v;
          end
        end
      endcase
      write_reg(plce_pkg::REG_RANGE_MIN, lo_v);
      write_reg(plce_pkg::REG_RANGE_MAX, hi_v);
      if (ph == 5) write_reg(REG_UNMAPPED_B, POS_W'($urandom_range(0, 24'hFFFFFF)));
      calm = (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r.cmd = ($urandom_range(0, 99) < ((node_cnt < MAX_NODES) ? 30 : 8))
                ? plce_pkg::CMD_ADD : plce_pkg::CMD_EVAL;
        r.node_pos = POS_W'($urandom_range(0, 24'hFFFFFF));
        if (r.cmd == plce_pkg::CMD_ADD && $urandom_range(0, 9) != 0) begin
          next_pos += longint'($urandom_range(0, 1 << 19));
          if (next_pos > 64'sd8388607) next_pos = 64'sd8388607;
          r.node_pos = next_pos[POS_W-1:0];
        end
        for (int c = 0; c < NCH; c++) begin
          case ($urandom_range(0, 7))
            0:       r.val[c] = '0;
            1:       r.val[c] = 16'hFFFF;
            2:       r.val[c] = 16'h8000;
            default: r.val[c] = VAL_W'($urandom_range(0, 16'hFFFF));
          endcase
        end
        case ($urandom_range(0, 9))
          0: begin
            case ($urandom_range(0, 2))
              0:       r.sample = '0;
              1:       r.sample = 17'd65535;
              default: r.sample = 17'd65536;
            endcase
          end
          1:       r.sample = SAMPLE_W'($urandom_range(65537, 131071));
          default: r.sample = SAMPLE_W'($urandom_range(0, 65536));
        endcase
        send_request(r, 1'b0);
      end
    end

    calm = 1'b0;
    req_if.valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
